// ===== src/ipid_pkg.sv =====
// Shared types and register indexes for the incremental PID controller.
package ipid_pkg;

   localparam int unsigned DATA_W  = 32;
   localparam int unsigned LIMIT_W = 15;
   localparam int unsigned FRAC_W  = 16;
   localparam int unsigned INDEX_W = 3;

   localparam logic [INDEX_W-1:0] REG_PROP_GAIN    = 3'd0;
   localparam logic [INDEX_W-1:0] REG_INTEG_GAIN   = 3'd1;
   localparam logic [INDEX_W-1:0] REG_DERIV_GAIN   = 3'd2;
   localparam logic [INDEX_W-1:0] REG_INTEG_LIMIT  = 3'd3;
   localparam logic [INDEX_W-1:0] REG_OUTPUT_LIMIT = 3'd4;

   typedef struct packed {
      logic signed [DATA_W-1:0] setpoint;
      logic signed [DATA_W-1:0] measured;
   } req_type;

   typedef struct packed {
      logic signed [DATA_W-1:0] drive;
      logic                     drive_clamped;
   } rsp_type;

   typedef struct packed {
      logic signed [DATA_W-1:0] prop_gain;
      logic signed [DATA_W-1:0] integ_gain;
      logic signed [DATA_W-1:0] deriv_gain;
      logic [LIMIT_W-1:0]       integ_limit;
      logic [LIMIT_W-1:0]       output_limit;
   } cfg_type;

   typedef struct packed {
      logic signed [DATA_W-1:0] prev_error;
      logic signed [DATA_W-1:0] prev_prev_error;
      logic signed [DATA_W-1:0] drive_total;
   } hist_type;

endpackage

// ===== src/incremental_pid_controller.sv =====
// Top level of the incremental PID controller: handshakes, registers and history.
// Incremental (velocity-form) PID in signed Q16.16. Each accepted item carries a
// setpoint and a measurement and yields exactly one result: the clamped drive
// total and a flag set when the output limit clipped it. An item lands in an input
// register, the whole step (error, three 32x32 gain products, integral and output
// clamps) runs in one combinational pass into the result register, so the block
// takes one item per clock cycle while the result register is free or drained;
// the error history and drive total update as each result is registered. The
// user must write gains and limits through the csr port only while the block is
// idle (not enforced by the block); indexes beyond the last register are ignored.
module incremental_pid_controller (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  ipid_pkg::req_type                     req_data,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output ipid_pkg::rsp_type                     rsp_data,
   input  logic                                  csr_we,
   input  logic [ipid_pkg::INDEX_W-1:0]          csr_index,
   input  logic [ipid_pkg::DATA_W-1:0]           csr_wdata
);
   import ipid_pkg::*;

   logic     in_valid_ff;
   logic     in_valid_in;
   req_type  in_data_ff;
   logic     out_valid_ff;
   logic     out_valid_in;
   rsp_type  out_data_ff;
   cfg_type  cfg_ff;
   cfg_type  cfg_in;
   hist_type hist_ff;
   hist_type hist_next;
   rsp_type  step_rsp;
   logic     advance;

   // The step moves into the result register whenever that register is free
   // or being drained in this cycle.
   assign advance   = in_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;
   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_data_ff;

   ipid_datapath u_datapath (
      .req       (in_data_ff),
      .cfg       (cfg_ff),
      .hist      (hist_ff),
      .rsp       (step_rsp),
      .hist_next (hist_next)
   );

   always_comb begin
      in_valid_in  = in_valid_ff;
      out_valid_in = out_valid_ff;
      if (req_valid && req_ready) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
      if (advance) begin
         out_valid_in = 1'b1;
      end else if (rsp_ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index)
            REG_PROP_GAIN:    cfg_in.prop_gain    = csr_wdata;
            REG_INTEG_GAIN:   cfg_in.integ_gain   = csr_wdata;
            REG_DERIV_GAIN:   cfg_in.deriv_gain   = csr_wdata;
            REG_INTEG_LIMIT:  cfg_in.integ_limit  = csr_wdata[LIMIT_W-1:0];
            REG_OUTPUT_LIMIT: cfg_in.output_limit = csr_wdata[LIMIT_W-1:0];
            default:          cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff         <= 1'b0;
         out_valid_ff        <= 1'b0;
         cfg_ff.prop_gain    <= '0;
         cfg_ff.integ_gain   <= '0;
         cfg_ff.deriv_gain   <= '0;
         cfg_ff.integ_limit  <= '1;
         cfg_ff.output_limit <= '1;
         hist_ff             <= '0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         cfg_ff       <= cfg_in;
         if (advance) begin
            hist_ff <= hist_next;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_data_ff <= req_data;
      end
      if (advance) begin
         out_data_ff <= step_rsp;
      end
   end

endmodule

// ===== src/ipid_datapath.sv =====
// Combinational PID step: error, three gain terms, clamps and new history.
module ipid_datapath (
   input  ipid_pkg::req_type  req,
   input  ipid_pkg::cfg_type  cfg,
   input  ipid_pkg::hist_type hist,
   output ipid_pkg::rsp_type  rsp,
   output ipid_pkg::hist_type hist_next
);
   import ipid_pkg::*;

   function automatic logic signed [31:0] sat33(input logic signed [32:0] x);
      if (x[32] != x[31]) begin
         return x[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
      end
      return x[31:0];
   endfunction

   function automatic logic signed [31:0] sat35(input logic signed [34:0] x);
      if (x[34:31] != {4{x[34]}}) begin
         return x[34] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
      end
      return x[31:0];
   endfunction

   // Product shifted right by the fraction width with floor rounding,
   // which is just dropping the low bits of the two's-complement product.
   function automatic logic signed [31:0] fx_mul(input logic signed [31:0] gain,
                                                input logic signed [31:0] val);
      logic signed [63:0] prod;
      logic signed [47:0] shifted;
      prod    = gain * val;
      shifted = prod[63:16];
      if (shifted[47:31] != {17{shifted[47]}}) begin
         return shifted[47] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
      end
      return shifted[31:0];
   endfunction

   logic signed [32:0] err_wide;
   logic signed [31:0] err;
   logic signed [32:0] d1_wide;
   logic signed [34:0] d2_wide;
   logic signed [31:0] d1;
   logic signed [31:0] d2;
   logic signed [31:0] p_term;
   logic signed [31:0] i_raw;
   logic signed [31:0] i_term;
   logic signed [31:0] d_term;
   logic signed [31:0] ilim;
   logic signed [31:0] ilim_neg;
   logic signed [33:0] olim;
   logic signed [33:0] sum;
   logic signed [33:0] sum_clamped;
   logic               clamped;

   always_comb begin
      err_wide = {req.setpoint[31], req.setpoint} - {req.measured[31], req.measured};
      err      = sat33(err_wide);
      d1_wide  = {err[31], err} - {hist.prev_error[31], hist.prev_error};
      d2_wide  = {{3{err[31]}}, err}
                 - {{2{hist.prev_error[31]}}, hist.prev_error, 1'b0}
                 + {{3{hist.prev_prev_error[31]}}, hist.prev_prev_error};
      d1       = sat33(d1_wide);
      d2       = sat35(d2_wide);

      p_term = fx_mul(cfg.prop_gain, d1);
      i_raw  = fx_mul(cfg.integ_gain, err);
      d_term = fx_mul(cfg.deriv_gain, d2);

      ilim     = {1'b0, cfg.integ_limit, 16'h0000};
      ilim_neg = -ilim;
      if (i_raw > ilim) begin
         i_term = ilim;
      end else if (i_raw < ilim_neg) begin
         i_term = ilim_neg;
      end else begin
         i_term = i_raw;
      end

      sum = {{2{hist.drive_total[31]}}, hist.drive_total}
            + {{2{p_term[31]}}, p_term}
            + {{2{i_term[31]}}, i_term}
            + {{2{d_term[31]}}, d_term};
      olim = {3'b000, cfg.output_limit, 16'h0000};
      if (sum > olim) begin
         sum_clamped = olim;
         clamped     = 1'b1;
      end else if (sum < -olim) begin
         sum_clamped = -olim;
         clamped     = 1'b1;
      end else begin
         sum_clamped = sum;
         clamped     = 1'b0;
      end

      rsp.drive                 = sum_clamped[31:0];
      rsp.drive_clamped         = clamped;
      hist_next.prev_error      = err;
      hist_next.prev_prev_error = hist.prev_error;
      hist_next.drive_total     = sum_clamped[31:0];
   end

endmodule

// ===== tb/sv/ipid_checker.sv =====
// Checker for the incremental PID controller: predicts every drive result and compares it.
module ipid_checker
   import ipid_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   input  logic               req_ready,
   input  req_type            req_data,
   input  logic               rsp_valid,
   input  logic               rsp_ready,
   input  rsp_type            rsp_data,
   input  logic               csr_we,
   input  logic [INDEX_W-1:0] csr_index,
   input  logic [DATA_W-1:0]  csr_wdata,
   output int                 pending,
   output int                 errors
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam longint WORD_MAX = 64'sd2147483647;
   localparam longint WORD_MIN = -64'sd2147483648;

   cfg_type  tuning;
   hist_type hist;
   rsp_type  drive_q[$];
   int       mismatch_count = 0;

   function automatic logic signed [DATA_W-1:0] sat_word(longint value);
      if (value > WORD_MAX) return WORD_MAX[DATA_W-1:0];
      if (value < WORD_MIN) return WORD_MIN[DATA_W-1:0];
      return value[DATA_W-1:0];
   endfunction

   // Exact 64-bit product; the arithmetic shift rounds toward minus infinity.
   function automatic logic signed [DATA_W-1:0] scale(logic signed [DATA_W-1:0] gain,
                                                      logic signed [DATA_W-1:0] operand);
      longint product;
      product = longint'(gain) * longint'(operand);
      return sat_word(product >>> FRAC_W);
   endfunction

   // One controller step: updates the error history and drive total.
   function automatic rsp_type pid_step(req_type item);
      logic signed [DATA_W-1:0] err, slope, curve, p_term, i_term, d_term;
      longint i_bound, o_bound, total;
      rsp_type result;
      err   = sat_word(longint'(item.setpoint) - longint'(item.measured));
      slope = sat_word(longint'(err) - longint'(hist.prev_error));
      curve = sat_word(longint'(err) - 2 * longint'(hist.prev_error)
                       + longint'(hist.prev_prev_error));
      i_bound = longint'(tuning.integ_limit) << FRAC_W;
      o_bound = longint'(tuning.output_limit) << FRAC_W;
      p_term = scale(tuning.prop_gain, slope);
      i_term = scale(tuning.integ_gain, err);
      d_term = scale(tuning.deriv_gain, curve);

      total = longint'(i_term);
      if (total > i_bound) total = i_bound;
      else if (total < -i_bound) total = -i_bound;

      total = total + longint'(hist.drive_total) + longint'(p_term) + longint'(d_term);
      result.drive_clamped = 1'b0;
      if (total > o_bound) begin
         total = o_bound;
         result.drive_clamped = 1'b1;
      end else if (total < -o_bound) begin
         total = -o_bound;
         result.drive_clamped = 1'b1;
      end

      hist.prev_prev_error = hist.prev_error;
      hist.prev_error      = err;
      hist.drive_total     = total[DATA_W-1:0];
      result.drive         = hist.drive_total;
      return result;
   endfunction

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         tuning.prop_gain    = '0;
         tuning.integ_gain   = '0;
         tuning.deriv_gain   = '0;
         tuning.integ_limit  = '1;
         tuning.output_limit = '1;
         hist = '0;
         drive_q.delete();
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (drive_q.size() == 0) begin
               $display("%0t: result with none expected: drive=%0d clamped=%0b",
                        $time, rsp_data.drive, rsp_data.drive_clamped);
               mismatch_count++;
            end else begin
               want = drive_q.pop_front();
               if (rsp_data.drive !== want.drive) begin
                  $display("%0t: drive expected %0d, got %0d",
                           $time, want.drive, rsp_data.drive);
                  mismatch_count++;
               end
               if (rsp_data.drive_clamped !== want.drive_clamped) begin
                  $display("%0t: drive_clamped expected %0b, got %0b",
                           $time, want.drive_clamped, rsp_data.drive_clamped);
                  mismatch_count++;
               end
            end
         end
         if (req_valid && req_ready) drive_q.push_back(pid_step(req_data));
         if (csr_we) begin
            case (csr_index)
               REG_PROP_GAIN:    tuning.prop_gain    = csr_wdata;
               REG_INTEG_GAIN:   tuning.integ_gain   = csr_wdata;
               REG_DERIV_GAIN:   tuning.deriv_gain   = csr_wdata;
               REG_INTEG_LIMIT:  tuning.integ_limit  = csr_wdata[LIMIT_W-1:0];
               REG_OUTPUT_LIMIT: tuning.output_limit = csr_wdata[LIMIT_W-1:0];
               default: ;
            endcase
         end
      end
      pending <= drive_q.size();
      errors  <= mismatch_count;
   end

endmodule

// ===== tb/sv/tb.sv =====
// Testbench top for the incremental PID controller: stimulus, watchdog and verdict.
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   import ipid_pkg::*;

   localparam int STALL_LIMIT   = 1000;
   localparam int SETTLE_CYCLES = 4;
   localparam int RANDOM_PHASES = 10;
   localparam int PHASE_ITEMS   = 68;

   localparam logic signed [DATA_W-1:0] WORD_MAX = 32'sh7fff_ffff;
   localparam logic signed [DATA_W-1:0] WORD_MIN = 32'sh8000_0000;
   localparam logic signed [DATA_W-1:0] ONE      = 32'sh0001_0000;
   localparam logic signed [DATA_W-1:0] HALF     = 32'sh0000_8000;
   localparam logic signed [DATA_W-1:0] QUARTER  = 32'sh0000_4000;
   localparam logic [DATA_W-1:0]        LIMIT_MAX = 32'h0000_7fff;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_ready;
   req_type            req_data = '0;
   logic               rsp_valid;
   logic               rsp_ready = 1'b0;
   rsp_type            rsp_data;
   logic               csr_we = 1'b0;
   logic [INDEX_W-1:0] csr_index = '0;
   logic [DATA_W-1:0]  csr_wdata = '0;
   int                 pending;
   int                 errors;
   int                 req_max_gap = 8;
   int                 rsp_max_gap = 8;
   int                 quiet_cycles = 0;

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   incremental_pid_controller DUT (
      .clock, .reset, .req_valid, .req_ready, .req_data,
      .rsp_valid, .rsp_ready, .rsp_data, .csr_we, .csr_index, .csr_wdata
   );

   ipid_checker drive_check (
      .clock, .reset, .req_valid, .req_ready, .req_data,
      .rsp_valid, .rsp_ready, .rsp_data, .csr_we, .csr_index, .csr_wdata,
      .pending, .errors
   );

   // Entered and left at a falling edge; valid stays high when no gap is drawn.
   task automatic send(input logic signed [DATA_W-1:0] setpoint,
                       input logic signed [DATA_W-1:0] measured);
      int gap;
      gap = $urandom_range(req_max_gap, 0);
      if (gap > 0) begin
         req_valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_data.setpoint = setpoint;
      req_data.measured = measured;
      req_valid = 1'b1;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      @(negedge clock);
   endtask

   // Stops sending and waits until every outstanding result has been taken.
   task automatic drain();
      req_valid = 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic write_reg(input logic [INDEX_W-1:0] index, input logic [DATA_W-1:0] value);
      csr_we    = 1'b1;
      csr_index = index;
      csr_wdata = value;
      @(negedge clock);
      csr_we = 1'b0;
   endtask

   task automatic load_tuning(input logic [DATA_W-1:0] kp, ki, kd, ilim, olim);
      write_reg(REG_PROP_GAIN, kp);
      write_reg(REG_INTEG_GAIN, ki);
      write_reg(REG_DERIV_GAIN, kd);
      write_reg(REG_INTEG_LIMIT, ilim);
      write_reg(REG_OUTPUT_LIMIT, olim);
   endtask

   // Mostly values within +/-100.0 so the drive moves without always saturating.
   function automatic logic signed [DATA_W-1:0] pick_value();
      case ($urandom_range(9, 0))
         0: return WORD_MAX;
         1: return WORD_MIN;
         2, 3: return $urandom();
         default: return $signed($urandom_range(32'd13107200, 0)) - 32'sd6553600;
      endcase
   endfunction

   function automatic logic signed [DATA_W-1:0] pick_gain();
      case ($urandom_range(7, 0))
         0: return '0;
         1: return WORD_MAX;
         2: return WORD_MIN;
         3: return $urandom();
         default: return $signed($urandom_range(32'd262144, 0)) - 32'sd131072;
      endcase
   endfunction

   // Full random words also exercise the upper write-data bits that a limit ignores.
   function automatic logic [DATA_W-1:0] pick_limit();
      case ($urandom_range(5, 0))
         0: return '0;
         1: return LIMIT_MAX;
         2: return $urandom();
         default: return $urandom_range(200, 1);
      endcase
   endfunction

   initial begin
      int stall;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         stall = $urandom_range(rsp_max_gap, 0);
         if (stall > 0) begin
            rsp_ready = 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_ready = 1'b1;
         @(posedge clock);
         while (!rsp_valid) @(posedge clock);
         @(negedge clock);
      end
   end

   always @(posedge clock) begin
      if (reset || csr_we || (req_valid && req_ready) || (rsp_valid && rsp_ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   initial begin
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // All gains are zero out of reset, so the drive has to stay at zero.
      send(WORD_MAX, WORD_MIN);
      send(WORD_MIN, WORD_MAX);
      send('0, '0);
      drain();

      // Writes past the last register must leave the settings alone.
      for (int idx = int'(REG_OUTPUT_LIMIT) + 1; idx < (1 << INDEX_W); idx++)
         write_reg(INDEX_W'(idx), $urandom());
      load_tuning(ONE, HALF, QUARTER, LIMIT_MAX, LIMIT_MAX);
      // Error saturation, then both difference terms saturating in each direction.
      send(WORD_MAX, WORD_MIN);
      send(WORD_MIN, WORD_MAX);
      send(WORD_MAX, WORD_MIN);
      send(32'sh1234_5678, 32'sh0fed_cba9);
      send(-5, 3);
      drain();

      // Extreme gains saturate the products; a tiny integral limit clamps that term.
      load_tuning(WORD_MAX, WORD_MIN, WORD_MIN, 32'd1, LIMIT_MAX);
      send(WORD_MAX, WORD_MIN);
      send(WORD_MIN, WORD_MAX);
      send(1, 0);
      send(-1, 0);
      drain();

      // Integral only: pin the drive at the limit, then land exactly on each limit.
      load_tuning('0, ONE, '0, LIMIT_MAX, 32'd10);
      send(WORD_MAX, '0);
      send(WORD_MAX, '0);
      send('0, '0);
      send(-20 * ONE, '0);
      send('0, ONE);
      drain();

      // Zero limits force the integral term and the drive to zero.
      load_tuning(WORD_MAX, '0, '0, '0, '0);
      send(WORD_MAX, '0);
      send(WORD_MIN, '0);
      send(3 * ONE, 1);

      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         drain();
         if ($urandom_range(3, 0) == 0)
            write_reg(INDEX_W'(int'(REG_OUTPUT_LIMIT) + 1 + int'($urandom_range(2, 0))),
                      $urandom());
         load_tuning(pick_gain(), pick_gain(), pick_gain(), pick_limit(), pick_limit());
         req_max_gap = (phase % 3 == 0) ? 0 : 8;
         rsp_max_gap = (phase % 2 == 0) ? 0 : 8;
         repeat (PHASE_ITEMS) send(pick_value(), pick_value());
      end

      drain();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (errors == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

endmodule

// ===== incremental_pid_controller.f =====
src/ipid_pkg.sv
src/ipid_datapath.sv
src/incremental_pid_controller.sv
tb/sv/ipid_checker.sv
tb/sv/tb.sv
